### rtl/tsgc_pkg.sv
// ----------------------------------------------------------------------------
// Three-stop gradient color package
// Default widths and register indexes shared by the gradient color modules.
// ----------------------------------------------------------------------------
package tsgc_pkg;

  localparam int DEF_CHANNEL_BITS  = 8;
  localparam int DEF_POSITION_BITS = 16;

  localparam int REG_INDEX_BITS = 3;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_STOP_A_POS   = 3'd0,
    REG_STOP_B_POS   = 3'd1,
    REG_STOP_C_POS   = 3'd2,
    REG_STOP_A_COLOR = 3'd3,
    REG_STOP_B_COLOR = 3'd4,
    REG_STOP_C_COLOR = 3'd5
  } reg_idx_t;

endpackage

### rtl/tsgc_div.sv
// ----------------------------------------------------------------------------
// Gradient channel divider
// Pipelined restoring divider for one color channel, one quotient bit per
// stage, followed by the signed add onto the low stop's channel value.
// ----------------------------------------------------------------------------
module tsgc_div #(
  parameter int CHANNEL_BITS  = tsgc_pkg::DEF_CHANNEL_BITS,
  parameter int POSITION_BITS = tsgc_pkg::DEF_POSITION_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic [POSITION_BITS+CHANNEL_BITS-1:0] in_mag,
  input  logic [POSITION_BITS-1:0]              in_den,
  input  logic                                  in_neg,
  input  logic [CHANNEL_BITS-1:0]               in_clo,
  output logic                                  out_valid,
  output logic [CHANNEL_BITS-1:0]               out_chan
);
  import tsgc_pkg::*;

  localparam int C = CHANNEL_BITS;
  localparam int P = POSITION_BITS;
  localparam int W = P + C;

  logic [C-1:0] vld;
  logic [W-1:0] rem [C];
  logic [P-1:0] den [C];
  logic [C-1:0] quo [C];
  logic         neg [C];
  logic [C-1:0] clo [C];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[C-2:0], in_valid};
    end
  end

  for (genvar j = 0; j < C; j++) begin : g_stage
    localparam int BIT = C - 1 - j;

    logic [W-1:0] src_rem;
    logic [P-1:0] src_den;
    logic [C-1:0] src_quo;
    logic         src_neg;
    logic [C-1:0] src_clo;
    logic [W-1:0] den_sh;
    logic [W:0]   trial;

    if (j == 0) begin : g_first
      assign src_rem = in_mag;
      assign src_den = in_den;
      assign src_quo = '0;
      assign src_neg = in_neg;
      assign src_clo = in_clo;
    end else begin : g_next
      assign src_rem = rem[j-1];
      assign src_den = den[j-1];
      assign src_quo = quo[j-1];
      assign src_neg = neg[j-1];
      assign src_clo = clo[j-1];
    end

    assign den_sh = W'(src_den) << BIT;
    assign trial  = {1'b0, src_rem} - {1'b0, den_sh};

    always_ff @(posedge clk) begin
      den[j] <= src_den;
      neg[j] <= src_neg;
      clo[j] <= src_clo;
      if (!trial[W]) begin
        rem[j]      <= trial[W-1:0];
        quo[j]      <= src_quo | (C'(1) << BIT);
      end else begin
        rem[j]      <= src_rem;
        quo[j]      <= src_quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[C-1];
    end
    if (neg[C-1]) begin
      out_chan <= clo[C-1] - quo[C-1];
    end else begin
      out_chan <= clo[C-1] + quo[C-1];
    end
  end

endmodule

### rtl/three_stop_gradient_color.sv
// ----------------------------------------------------------------------------
// Three-stop gradient color
// Maps a gradient position to an RGBA color by interpolating between three
// configured color stops, which are kept sorted by position.
// ----------------------------------------------------------------------------
//  Channel   Ports                                         Handshake
//  config    psel penable pwrite paddr pwdata prdata       APB, pready high
//  input     start busy position                           start and not busy
//  result    done red green blue alpha                     done for one cycle
//
// A new word is taken on every cycle while not busy; each result passes the
// capture, operand, product and one-bit-per-stage divider stages in order.
// Busy is high only while reset is held; reset clears all pipeline valids
// and restores the register defaults. The result side never stalls.
// ----------------------------------------------------------------------------
module three_stop_gradient_color #(
  parameter int CHANNEL_BITS  = tsgc_pkg::DEF_CHANNEL_BITS,
  parameter int POSITION_BITS = tsgc_pkg::DEF_POSITION_BITS,
  localparam int DATA_BITS    = (4 * CHANNEL_BITS > 32) ? 64 : 32,
  localparam int ADDR_LSB     = (4 * CHANNEL_BITS > 32) ? 3 : 2,
  localparam int ADDR_BITS    = ADDR_LSB + tsgc_pkg::REG_INDEX_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_BITS-1:0]     paddr,
  input  logic [DATA_BITS-1:0]     pwdata,
  output logic [DATA_BITS-1:0]     prdata,
  output logic                     pready,
  input  logic                     start,
  output logic                     busy,
  input  logic [POSITION_BITS-1:0] position,
  output logic                     done,
  output logic [CHANNEL_BITS-1:0]  red,
  output logic [CHANNEL_BITS-1:0]  green,
  output logic [CHANNEL_BITS-1:0]  blue,
  output logic [CHANNEL_BITS-1:0]  alpha
);
  import tsgc_pkg::*;

  localparam int C  = CHANNEL_BITS;
  localparam int P  = POSITION_BITS;
  localparam int CB = 4 * C;

  localparam logic [P-1:0] RST_A_POS = P'(0);
  localparam logic [P-1:0] RST_B_POS = P'(16384);
  localparam logic [P-1:0] RST_C_POS = P'(32768);

  logic [P-1:0]  pos_a, pos_b, pos_c;
  logic [CB-1:0] color_a, color_b, color_c;
  logic          wr_en;
  reg_idx_t      reg_idx;

  assign pready  = 1'b1;
  assign busy    = rst;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[ADDR_BITS-1:ADDR_LSB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_a   <= RST_A_POS;
      pos_b   <= RST_B_POS;
      pos_c   <= RST_C_POS;
      color_a <= '0;
      color_b <= '0;
      color_c <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_STOP_A_POS:   pos_a   <= pwdata[P-1:0];
        REG_STOP_B_POS:   pos_b   <= pwdata[P-1:0];
        REG_STOP_C_POS:   pos_c   <= pwdata[P-1:0];
        REG_STOP_A_COLOR: color_a <= pwdata[CB-1:0];
        REG_STOP_B_COLOR: color_b <= pwdata[CB-1:0];
        REG_STOP_C_COLOR: color_c <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STOP_A_POS:   prdata = DATA_BITS'(pos_a);
      REG_STOP_B_POS:   prdata = DATA_BITS'(pos_b);
      REG_STOP_C_POS:   prdata = DATA_BITS'(pos_c);
      REG_STOP_A_COLOR: prdata = DATA_BITS'(color_a);
      REG_STOP_B_COLOR: prdata = DATA_BITS'(color_b);
      REG_STOP_C_COLOR: prdata = DATA_BITS'(color_c);
      default:          prdata = '0;
    endcase
  end

  // Stable sort of the stops: compare-swap first/second, second/third,
  // then first/second again, swapping only on strictly greater positions.
  logic [P-1:0]  x_pos0, x_pos1, y_pos1, y_pos2, z_pos0, z_pos1;
  logic [CB-1:0] x_col0, x_col1, y_col1, y_col2, z_col0, z_col1;

  always_comb begin
    if (pos_a > pos_b) begin
      x_pos0 = pos_b;   x_col0 = color_b;
      x_pos1 = pos_a;   x_col1 = color_a;
    end else begin
      x_pos0 = pos_a;   x_col0 = color_a;
      x_pos1 = pos_b;   x_col1 = color_b;
    end
    if (x_pos1 > pos_c) begin
      y_pos1 = pos_c;   y_col1 = color_c;
      y_pos2 = x_pos1;  y_col2 = x_col1;
    end else begin
      y_pos1 = x_pos1;  y_col1 = x_col1;
      y_pos2 = pos_c;   y_col2 = color_c;
    end
    if (x_pos0 > y_pos1) begin
      z_pos0 = y_pos1;  z_col0 = y_col1;
      z_pos1 = x_pos0;  z_col1 = x_col0;
    end else begin
      z_pos0 = x_pos0;  z_col0 = x_col0;
      z_pos1 = y_pos1;  z_col1 = y_col1;
    end
  end

  logic [P-1:0]  spos0, spos1, spos2;
  logic [CB-1:0] scol0, scol1, scol2;

  always_ff @(posedge clk) begin
    if (rst) begin
      spos0 <= RST_A_POS;
      spos1 <= RST_B_POS;
      spos2 <= RST_C_POS;
      scol0 <= '0;
      scol1 <= '0;
      scol2 <= '0;
    end else begin
      spos0 <= z_pos0;
      spos1 <= z_pos1;
      spos2 <= y_pos2;
      scol0 <= z_col0;
      scol1 <= z_col1;
      scol2 <= y_col2;
    end
  end

  // Stage 1: capture the position.
  logic         v1;
  logic [P-1:0] p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    p1 <= position;
  end

  // Stage 2: pick the segment and form the operands.
  logic          byp;
  logic [P-1:0]  slo, shi;
  logic [CB-1:0] col_lo, col_hi;

  always_comb begin
    if (p1 <= spos0) begin
      byp = 1'b1;  slo = spos0;  shi = spos0;  col_lo = scol0;  col_hi = scol0;
    end else if (p1 <= spos1) begin
      byp = 1'b0;  slo = spos0;  shi = spos1;  col_lo = scol0;  col_hi = scol1;
    end else if (p1 <= spos2) begin
      byp = 1'b0;  slo = spos1;  shi = spos2;  col_lo = scol1;  col_hi = scol2;
    end else begin
      byp = 1'b1;  slo = spos2;  shi = spos2;  col_lo = scol2;  col_hi = scol2;
    end
  end

  logic         v2;
  logic [P-1:0] d2, den2;
  logic [C-1:0] clo2 [4];
  logic [C-1:0] dabs2 [4];
  logic         neg2 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    if (byp) begin
      d2   <= '0;
      den2 <= P'(1);
    end else begin
      d2   <= p1 - slo;
      den2 <= shi - slo;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_operand
    logic [C-1:0] ch_lo, ch_hi;

    assign ch_lo = col_lo[(3-k)*C +: C];
    assign ch_hi = col_hi[(3-k)*C +: C];

    always_ff @(posedge clk) begin
      clo2[k] <= ch_lo;
      neg2[k] <= ch_hi < ch_lo;
      if (ch_hi < ch_lo) begin
        dabs2[k] <= ch_lo - ch_hi;
      end else begin
        dabs2[k] <= ch_hi - ch_lo;
      end
    end
  end

  // Stage 3: product of the offset and the channel span.
  logic         v3;
  logic [P-1:0] den3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    den3 <= den2;
  end

  logic [3:0]   lane_vld;
  logic [C-1:0] chan [4];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [P+C-1:0] mag3;
    logic           neg3;
    logic [C-1:0]   clo3;

    always_ff @(posedge clk) begin
      mag3 <= (P+C)'(d2) * (P+C)'(dabs2[k]);
      neg3 <= neg2[k];
      clo3 <= clo2[k];
    end

    tsgc_div #(
      .CHANNEL_BITS  (C),
      .POSITION_BITS (P)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v3),
      .in_mag    (mag3),
      .in_den    (den3),
      .in_neg    (neg3),
      .in_clo    (clo3),
      .out_valid (lane_vld[k]),
      .out_chan  (chan[k])
    );
  end

  assign done  = lane_vld[0];
  assign red   = chan[0];
  assign green = chan[1];
  assign blue  = chan[2];
  assign alpha = chan[3];

`ifndef SYNTHESIS
  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> v1)
    else $error("accepted word did not enter the pipeline");

  a_den_nonzero : assert property (@(posedge clk) disable iff (rst)
    v2 |-> (den2 != '0))
    else $error("zero divisor reached the divider");

  a_stops_sorted : assert property (@(posedge clk) disable iff (rst)
    (spos0 <= spos1) && (spos1 <= spos2))
    else $error("sorted stop positions out of order");

  a_latency : assert property (@(posedge clk) disable iff (rst)
    v3 |-> ##(C+1) done)
    else $error("result did not appear at the fixed latency");

  a_lanes_agree : assert property (@(posedge clk) disable iff (rst)
    (lane_vld == 4'b0000) || (lane_vld == 4'b1111))
    else $error("channel lanes out of step");
`endif

endmodule

### test/tb_three_stop_gradient_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-stop gradient color testbench
// Programs the three color stops over the register port and streams gradient
// positions in bursts. Each returned color is compared, field by field, with
// the color worked out independently from the current stop registers.
// ----------------------------------------------------------------------------
module tb_three_stop_gradient_color;
  import tsgc_pkg::*;

  localparam int CH_W        = DEF_CHANNEL_BITS;
  localparam int POS_W       = DEF_POSITION_BITS;
  localparam int COLOR_W     = 4 * CH_W;
  localparam int ADDR_W      = 2 + REG_INDEX_BITS;
  localparam int LATENCY     = CH_W + 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 850;
  localparam int MAX_PRINTED = 50;

  localparam logic [REG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [POS_W-1:0] POS_ONE = 16'd32768;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [COLOR_W-1:0] color;
  } color_stop_t;

  class color_scoreboard;
    logic [POS_W-1:0]   stop_pos [3];
    logic [COLOR_W-1:0] stop_color [3];
    rgba_t              pending_colors [$];
    int                 mismatches;

    function new();
      stop_pos   = '{16'd0, 16'd16384, POS_ONE};
      stop_color = '{'0, '0, '0};
      mismatches = 0;
    endfunction

    function void set_reg(logic [REG_INDEX_BITS-1:0] idx, logic [31:0] data);
      case (idx)
        REG_STOP_A_POS:   stop_pos[0] = data[POS_W-1:0];
        REG_STOP_B_POS:   stop_pos[1] = data[POS_W-1:0];
        REG_STOP_C_POS:   stop_pos[2] = data[POS_W-1:0];
        REG_STOP_A_COLOR: stop_color[0] = data[COLOR_W-1:0];
        REG_STOP_B_COLOR: stop_color[1] = data[COLOR_W-1:0];
        REG_STOP_C_COLOR: stop_color[2] = data[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CH_W-1:0] channel(color_stop_t s, int k);
      return s.color[(3 - k) * CH_W +: CH_W];
    endfunction

    function logic [CH_W-1:0] blend(color_stop_t lo, color_stop_t hi, int k,
                                    logic [POS_W-1:0] p);
      longint clo;
      longint chi;
      longint num;
      longint span;
      clo  = longint'(channel(lo, k));
      chi  = longint'(channel(hi, k));
      span = longint'(hi.pos) - longint'(lo.pos);
      if (span <= 0) return channel(lo, k);
      num = (longint'(p) - longint'(lo.pos)) * (chi - clo);
      return CH_W'(clo + num / span);
    endfunction

    function rgba_t predict_color(logic [POS_W-1:0] p);
      color_stop_t      s [3];
      color_stop_t      t;
      logic [CH_W-1:0]  ch [4];
      int               j;
      for (int i = 0; i < 3; i++) s[i] = '{stop_pos[i], stop_color[i]};
      // Stable sort: compare-swap pairs (0,1), (1,2), (0,1).
      for (int n = 0; n < 3; n++) begin
        j = (n == 1) ? 1 : 0;
        if (s[j].pos > s[j+1].pos) begin
          t = s[j];
          s[j] = s[j+1];
          s[j+1] = t;
        end
      end
      for (int k = 0; k < 4; k++) begin
        if (p <= s[0].pos) ch[k] = channel(s[0], k);
        else if (p <= s[1].pos) ch[k] = blend(s[0], s[1], k, p);
        else if (p <= s[2].pos) ch[k] = blend(s[1], s[2], k, p);
        else ch[k] = channel(s[2], k);
      end
      return '{ch[0], ch[1], ch[2], ch[3]};
    endfunction

    function void note_position(logic [POS_W-1:0] p);
      pending_colors.push_back(predict_color(p));
    endfunction

    task report_mismatch(string what);
      if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_color(rgba_t got);
      rgba_t want;
      if (pending_colors.size() == 0) begin
        report_mismatch($sformatf("color %h with no word pending", got));
      end else begin
        want = pending_colors.pop_front();
        if (got.red != want.red || got.green != want.green ||
            got.blue != want.blue || got.alpha != want.alpha)
          report_mismatch($sformatf("rgba got %h expected %h", got, want));
      end
    endtask
  endclass

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [ADDR_W-1:0]  paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start   = 1'b0;
  logic               busy;
  logic [POS_W-1:0]   position = '0;
  logic               done;
  logic [CH_W-1:0]    red;
  logic [CH_W-1:0]    green;
  logic [CH_W-1:0]    blue;
  logic [CH_W-1:0]    alpha;

  color_scoreboard colors;
  int              burst_left = 0;
  int unsigned     cycle_count = 0;

  three_stop_gradient_color u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .start    (start),
    .busy     (busy),
    .position (position),
    .done     (done),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .alpha    (alpha)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) colors.check_color(rgba_t'({red, green, blue, alpha}));
  end

  task automatic write_reg(input logic [REG_INDEX_BITS-1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    colors.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic send_word(input logic [POS_W-1:0] p);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 20);
    end
    burst_left--;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    position <= p;
    do @(posedge clk); while (busy);
    colors.note_position(p);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (colors.pending_colors.size() != 0);
  endtask

  function automatic logic [POS_W-1:0] pick_extreme();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return POS_ONE;
      default: return POS_MAX;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_stop_pos();
    case ($urandom_range(0, 5))
      0: return pick_extreme();
      1, 2, 3: return POS_W'($urandom_range(0, 32768));
      default: return POS_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4)
      return colors.stop_pos[$urandom_range(0, 2)] + POS_W'($urandom_range(0, 6)) - POS_W'(3);
    else if (sel < 7) return POS_W'($urandom_range(0, 32768));
    else if (sel < 9) return POS_W'($urandom_range(0, 65535));
    return pick_extreme();
  endfunction

  task automatic randomize_stops();
    logic [POS_W-1:0]          pos [3];
    logic [15:0]               junk;
    logic [31:0]               color;
    logic [REG_INDEX_BITS-1:0] pos_regs [3];
    logic [REG_INDEX_BITS-1:0] color_regs [3];
    pos_regs   = '{REG_STOP_A_POS, REG_STOP_B_POS, REG_STOP_C_POS};
    color_regs = '{REG_STOP_A_COLOR, REG_STOP_B_COLOR, REG_STOP_C_COLOR};
    for (int i = 0; i < 3; i++) pos[i] = pick_stop_pos();
    if ($urandom_range(0, 4) == 0) pos[1] = pos[0];
    if ($urandom_range(0, 4) == 0) pos[2] = pos[$urandom_range(0, 1)];
    for (int i = 0; i < 3; i++) begin
      junk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
      write_reg(pos_regs[i], {junk, pos[i]});
      case ($urandom_range(0, 7))
        0: color = '0;
        1: color = '1;
        default: color = $urandom;
      endcase
      write_reg(color_regs[i], color);
    end
    if ($urandom_range(0, 5) == 0)
      write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
  endtask

  initial begin
    logic [POS_W-1:0] default_stop_words [9] = '{16'd0, 16'd1, 16'd16383, 16'd16384,
                                                16'd16385, 16'd32767, 16'd32768, 16'd32769,
                                                16'd65535};
    logic [POS_W-1:0] unsorted_words [7] = '{16'd4999, 16'd5000, 16'd5001, 16'd29999,
                                            16'd30000, 16'd30001, 16'd65535};
    logic [POS_W-1:0] shared_stop_words [3] = '{16'd19999, 16'd20000, 16'd20001};
    logic [POS_W-1:0] over_one_words [6] = '{16'd0, 16'd1, 16'd39999, 16'd40000,
                                            16'd65534, 16'd65535};
    int random_words;
    int phase_words;

    colors = new();
    random_words = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset stop positions with distinct colors.
    write_reg(REG_STOP_A_COLOR, 32'h00FF00FF);
    write_reg(REG_STOP_B_COLOR, 32'hFF00FF80);
    write_reg(REG_STOP_C_COLOR, 32'h12345678);
    foreach (default_stop_words[i]) send_word(default_stop_words[i]);
    drain();

    // Stops out of order with a tie; junk in the upper data bits and writes
    // to unused addresses must have no effect.
    write_reg(REG_STOP_A_POS, 32'd30000);
    write_reg(REG_STOP_B_POS, 32'hFFFF0000 | 32'd5000);
    write_reg(REG_STOP_C_POS, 32'd5000);
    write_reg(REG_STOP_A_COLOR, 32'hFFFFFFFF);
    write_reg(REG_STOP_B_COLOR, 32'h00000000);
    write_reg(REG_STOP_C_COLOR, 32'h80808080);
    write_reg(REG_SPARE_LO, 32'hFFFFFFFF);
    write_reg(REG_SPARE_HI, 32'hFFFFFFFF);
    foreach (unsorted_words[i]) send_word(unsorted_words[i]);
    drain();

    // All three stops at one position.
    write_reg(REG_STOP_A_POS, 32'd20000);
    write_reg(REG_STOP_B_POS, 32'd20000);
    write_reg(REG_STOP_C_POS, 32'd20000);
    foreach (shared_stop_words[i]) send_word(shared_stop_words[i]);
    drain();

    // Stop positions beyond 1.0 are used unclamped.
    write_reg(REG_STOP_A_POS, 32'd65535);
    write_reg(REG_STOP_B_POS, 32'd40000);
    write_reg(REG_STOP_C_POS, 32'd0);
    foreach (over_one_words[i]) send_word(over_one_words[i]);

    while (random_words < RANDOM_WORDS) begin
      drain();
      randomize_stops();
      phase_words = $urandom_range(20, 80);
      repeat (phase_words) begin
        send_word(pick_position());
        random_words++;
      end
    end

    drain();
    repeat (3 * LATENCY) @(posedge clk);
    if (colors.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
